// ----- sv/lzwe_pkg.sv -----
// Shared types and constants of the variable-width LZW encoder.
package lzwe_pkg;

   // Parameter default and parameter-independent widths
   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int CFG_W             = 4;
   localparam int CSR_IDX_W         = 2;
   localparam int WID_W             = 5;
   localparam int ACC_W             = 23;
   localparam int EPOCH_W           = 8;
   localparam int FIRST_FREE        = 257;
   localparam int MAX_RESULTS       = 6;
   localparam int OUT_DEPTH         = 8;
   localparam int OUT_CW            = $clog2(OUT_DEPTH + 1);
   localparam int IN_DEPTH          = 2;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_START_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BITS   = 2'd1;
   localparam logic [CFG_W-1:0]     START_BITS_RST = 4'd9;
   localparam logic [CFG_W-1:0]     MAX_BITS_RST   = 4'd11;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       run_last;
      logic       stream_done;
   } rsp_word_type;

   // Write side of the result queue
   typedef struct packed {
      logic         push;
      rsp_word_type word;
   } outq_wr_type;

endpackage

// ----- sv/lzwe_front.sv -----
// Input queue: takes request words and hands them to the encoder core.
module lzwe_front import lzwe_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  req_word_type req_word,
   output logic         fwd_valid,
   output req_word_type fwd_word,
   input  logic         fwd_take
);

   req_word_type ent_ff [IN_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign req_full  = (cnt_ff == 2'(IN_DEPTH));
   assign fwd_valid = (cnt_ff != 2'd0);
   assign fwd_word  = ent_ff[rd_ptr_ff];
   assign do_push   = req_push && !req_full;
   assign do_pop    = fwd_take && fwd_valid;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store incoming word
   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= req_word;
      end
   end

endmodule

// ----- sv/lzwe_outq.sv -----
// Result queue: holds packed bytes until the consumer pops them.
module lzwe_outq import lzwe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  outq_wr_type       wr,
   output logic [OUT_CW-1:0] count,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output rsp_word_type      rsp_word
);

   localparam int PTR_W = $clog2(OUT_DEPTH);

   rsp_word_type      ent_ff [OUT_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUT_CW-1:0] cnt_ff, cnt_in;
   logic              do_pop;

   assign count     = cnt_ff;
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_word  = ent_ff[rd_ptr_ff];
   assign do_pop    = rsp_pop && !rsp_empty;

   // Advance pointers and count; the core never pushes into a full queue
   always_comb begin
      wr_ptr_in = wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + OUT_CW'(wr.push) - OUT_CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         ent_ff[wr_ptr_ff] <= wr.word;
      end
   end

endmodule

// ----- sv/lzwe_core.sv -----
// Encoder core: hashed dictionary search, code packing and stream control.
module lzwe_core import lzwe_pkg::*; #(
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 in_valid,
   input  req_word_type         in_word,
   output logic                 in_take,
   input  logic [OUT_CW-1:0]    out_count,
   output outq_wr_type          out_wr
);

   localparam int CODE_W  = MAX_CODE_BITS;
   localparam int NC_W    = CODE_W + 1;
   localparam int KEY_W   = CODE_W + 8;
   localparam int TBL_AW  = CODE_W + 1;
   localparam int TBL_D   = 1 << TBL_AW;
   localparam int SLOT_W  = EPOCH_W + KEY_W + CODE_W;
   localparam logic [NC_W-1:0] DICT_DEPTH = NC_W'(1) << CODE_W;

   typedef enum logic [6:0] {
      ST_SWEEP     = 7'b0000001,
      ST_IDLE      = 7'b0000010,
      ST_PROBE_RD  = 7'b0000100,
      ST_PROBE_CMP = 7'b0001000,
      ST_SEND      = 7'b0010000,
      ST_FIN       = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   // Hash table: epoch mark, key and code per slot
   logic [SLOT_W-1:0] mem [TBL_D];
   logic              mem_we;
   logic [TBL_AW-1:0] mem_waddr;
   logic [SLOT_W-1:0] mem_wdata;
   logic [SLOT_W-1:0] rdata_ff;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  start_bits_ff, start_bits_in;
   logic [CFG_W-1:0]  max_bits_ff, max_bits_in;
   logic [NC_W-1:0]   next_ff, next_in;
   logic [CODE_W-1:0] prefix_ff, prefix_in;
   logic              pvalid_ff, pvalid_in;
   logic [WID_W-1:0]  width_ff, width_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [WID_W-1:0]  tot_ff, tot_in;
   logic              hdr_ff, hdr_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic              sweep_pend_ff, sweep_pend_in;
   logic [TBL_AW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic [TBL_AW-1:0] addr_ff, addr_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              phase_ff, phase_in;
   logic [7:0]        pend_ff, pend_in;
   logic              pend_v_ff, pend_v_in;

   logic [WID_W-1:0]   eff_max;
   logic [ACC_W-1:0]   code_ext;
   logic [ACC_W-1:0]   packed_acc;
   logic [WID_W-1:0]   packed_tot;
   logic               grow;
   logic [WID_W-1:0]   w_next;
   logic [KEY_W-1:0]   key;
   logic [TBL_AW-1:0]  hash;
   logic [EPOCH_W-1:0] slot_epoch;
   logic [KEY_W-1:0]   slot_key;
   logic [CODE_W-1:0]  slot_code;
   logic               slot_live;
   logic [EPOCH_W-1:0] epoch_bump;
   logic               epoch_wrap;
   logic               emit_en;
   logic [7:0]         emit_byte;

   // Memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[addr_ff];
   end

   // Shared datapath terms
   always_comb begin
      eff_max    = ({1'b0, max_bits_ff} > WID_W'(CODE_W)) ? WID_W'(CODE_W)
                                                          : {1'b0, max_bits_ff};
      code_ext   = ACC_W'(prefix_ff) & ((ACC_W'(1) << width_ff) - ACC_W'(1));
      packed_acc = acc_ff | (code_ext << tot_ff);
      packed_tot = tot_ff + width_ff;
      grow       = ((next_ff >> width_ff) != '0);
      w_next     = width_ff + WID_W'(grow);
      key        = {prefix_ff, byte_ff};
      hash       = TBL_AW'(prefix_ff) ^ (TBL_AW'(in_word.data_byte) << (TBL_AW - 8));
      slot_epoch = rdata_ff[SLOT_W-1 -: EPOCH_W];
      slot_key   = rdata_ff[CODE_W +: KEY_W];
      slot_code  = rdata_ff[CODE_W-1:0];
      slot_live  = (slot_epoch == epoch_ff);
      epoch_wrap = (epoch_ff == '1);
      epoch_bump = epoch_wrap ? EPOCH_W'(1) : epoch_ff + 1'b1;
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      start_bits_in = start_bits_ff;
      max_bits_in   = max_bits_ff;
      next_in       = next_ff;
      prefix_in     = prefix_ff;
      pvalid_in     = pvalid_ff;
      width_in      = width_ff;
      acc_in        = acc_ff;
      tot_in        = tot_ff;
      hdr_in        = hdr_ff;
      epoch_in      = epoch_ff;
      sweep_pend_in = sweep_pend_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      addr_in       = addr_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      phase_in      = phase_ff;
      pend_in       = pend_ff;
      pend_v_in     = pend_v_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = {epoch_ff, key, next_ff[CODE_W-1:0]};
      in_take       = 1'b0;
      emit_en       = 1'b0;
      emit_byte     = acc_ff[7:0];
      out_wr        = '0;

      // Configuration writes
      if (csr_we) begin
         if (csr_idx == CSR_START_BITS) begin
            start_bits_in = csr_wdata;
         end else if (csr_idx == CSR_MAX_BITS) begin
            max_bits_in = csr_wdata;
         end
      end

      unique case (state_ff)
         ST_SWEEP: begin
            // Invalidate one slot per cycle
            mem_we       = 1'b1;
            mem_waddr    = sweep_cnt_ff;
            mem_wdata    = '0;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == '1) begin
               sweep_pend_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (sweep_pend_ff) begin
               sweep_cnt_in = '0;
               state_in     = ST_SWEEP;
            end else if (in_valid && (out_count <= OUT_CW'(OUT_DEPTH - MAX_RESULTS))) begin
               in_take  = 1'b1;
               byte_in  = in_word.data_byte;
               last_in  = in_word.end_of_input;
               phase_in = 1'b0;
               // Stream header
               if (!hdr_ff) begin
                  emit_en   = 1'b1;
                  emit_byte = 8'(eff_max);
                  hdr_in    = 1'b1;
                  next_in   = NC_W'(FIRST_FREE);
                  width_in  = WID_W'(start_bits_ff);
               end
               if (!pvalid_ff) begin
                  prefix_in = CODE_W'(in_word.data_byte);
                  pvalid_in = 1'b1;
                  state_in  = ST_FIN;
               end else begin
                  addr_in  = hash;
                  state_in = ST_PROBE_RD;
               end
            end
         end
         ST_PROBE_RD: begin
            state_in = ST_PROBE_CMP;
         end
         ST_PROBE_CMP: begin
            if (slot_live && (slot_key == key)) begin
               // Hit: extend the prefix
               prefix_in = slot_code;
               state_in  = ST_FIN;
            end else if (slot_live) begin
               // Occupied by another string: probe next slot
               addr_in  = addr_ff + 1'b1;
               state_in = ST_PROBE_RD;
            end else begin
               // Miss: send prefix, grow or clear, insert
               acc_in = packed_acc;
               tot_in = packed_tot;
               if (w_next > eff_max) begin
                  width_in = WID_W'(start_bits_ff);
                  next_in  = NC_W'(FIRST_FREE);
                  epoch_in = epoch_bump;
                  if (epoch_wrap) begin
                     sweep_pend_in = 1'b1;
                  end
               end else begin
                  width_in = w_next;
                  if (next_ff < DICT_DEPTH) begin
                     mem_we  = 1'b1;
                     next_in = next_ff + 1'b1;
                  end
               end
               prefix_in = CODE_W'(byte_ff);
               state_in  = ST_SEND;
            end
         end
         ST_SEND: begin
            // Drain whole bytes from the bit accumulator
            if (tot_ff >= WID_W'(8)) begin
               emit_en = 1'b1;
               acc_in  = acc_ff >> 8;
               tot_in  = tot_ff - WID_W'(8);
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (last_ff && !phase_ff) begin
               acc_in   = packed_acc;
               tot_in   = packed_tot;
               phase_in = 1'b1;
               state_in = ST_SEND;
            end else begin
               if (last_ff && (tot_ff != '0)) begin
                  emit_en = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Release the held byte with its item flags
            if (pend_v_ff) begin
               out_wr.push             = 1'b1;
               out_wr.word.packed_byte = pend_ff;
               out_wr.word.run_last    = 1'b1;
               out_wr.word.stream_done = last_ff;
            end
            pend_v_in = 1'b0;
            if (last_ff) begin
               next_in   = NC_W'(FIRST_FREE);
               prefix_in = '0;
               pvalid_in = 1'b0;
               width_in  = WID_W'(start_bits_ff);
               acc_in    = '0;
               tot_in    = '0;
               hdr_in    = 1'b0;
               epoch_in  = epoch_bump;
               if (epoch_wrap) begin
                  sweep_pend_in = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Hold each new byte back one step so the item's last one can be flagged
      if (emit_en) begin
         if (pend_v_ff) begin
            out_wr.push             = 1'b1;
            out_wr.word.packed_byte = pend_ff;
         end
         pend_in   = emit_byte;
         pend_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         start_bits_ff <= START_BITS_RST;
         max_bits_ff   <= MAX_BITS_RST;
         next_ff       <= NC_W'(FIRST_FREE);
         prefix_ff     <= '0;
         pvalid_ff     <= 1'b0;
         width_ff      <= WID_W'(START_BITS_RST);
         acc_ff        <= '0;
         tot_ff        <= '0;
         hdr_ff        <= 1'b0;
         epoch_ff      <= EPOCH_W'(1);
         sweep_pend_ff <= 1'b1;
         sweep_cnt_ff  <= '0;
         last_ff       <= 1'b0;
         phase_ff      <= 1'b0;
         pend_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         start_bits_ff <= start_bits_in;
         max_bits_ff   <= max_bits_in;
         next_ff       <= next_in;
         prefix_ff     <= prefix_in;
         pvalid_ff     <= pvalid_in;
         width_ff      <= width_in;
         acc_ff        <= acc_in;
         tot_ff        <= tot_in;
         hdr_ff        <= hdr_in;
         epoch_ff      <= epoch_in;
         sweep_pend_ff <= sweep_pend_in;
         sweep_cnt_ff  <= sweep_cnt_in;
         last_ff       <= last_in;
         phase_ff      <= phase_in;
         pend_v_ff     <= pend_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      byte_ff <= byte_in;
      pend_ff <= pend_in;
   end

endmodule

// ----- sv/lzw_variable_width_encoder.sv -----
// Top level of the variable-width LZW encoder.
// One uncompressed byte per word in, packed code bytes out (a header byte
// holding max_bits, capped at MAX_CODE_BITS, first, codes LSB first, final
// flush on end_of_input). After reset the dictionary hash table
// (2^(MAX_CODE_BITS+1) slots) is invalidated, one slot per cycle, and no
// word is taken during that pass; the same pass runs again after every 255
// dictionary clears or stream ends. A word that only starts a prefix passes
// through idle, finish and done. A lookup adds a read and a compare per hash
// probe; a miss then drains each whole output byte before finishing. The
// final word packs its prefix and drains the flushed bytes too; the header
// and the partial last byte need no state of their own. The probe loop over
// the hash table's single read port sets a word's cost. A 2-word input queue
// and an 8-byte result queue let producer and consumer stall independently;
// a word is taken only while at most two result bytes wait.
module lzw_variable_width_encoder import lzwe_pkg::*; #(
   parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_word_type         req_word,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_word_type         rsp_word,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic              fwd_valid;
   req_word_type      fwd_word;
   logic              fwd_take;
   logic [OUT_CW-1:0] out_count;
   outq_wr_type       out_wr;

   lzwe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .fwd_valid (fwd_valid),
      .fwd_word  (fwd_word),
      .fwd_take  (fwd_take)
   );

   lzwe_core #(
      .MAX_CODE_BITS (MAX_CODE_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .in_valid  (fwd_valid),
      .in_word   (fwd_word),
      .in_take   (fwd_take),
      .out_count (out_count),
      .out_wr    (out_wr)
   );

   lzwe_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .wr        (out_wr),
      .count     (out_count),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule

// ----- sv/lzwe_checker.sv -----
// Port-level checks of the LZW encoder, bound to the top level.
module lzwe_checker import lzwe_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_word_type rsp_word
);

   // Both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // The stream's final byte always closes its word's results
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (!rsp_word.stream_done || rsp_word.run_last))
      else $error("stream_done without run_last");

   // A waiting result is not dropped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result lost while stalled");

   // A waiting result does not change
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_word))
      else $error("result changed while stalled");

endmodule

bind lzw_variable_width_encoder lzwe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_word  (rsp_word)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the variable-width LZW encoder.
`timescale 1ns / 1ps

module tb_top;
   import lzwe_pkg::*;

   localparam int                   DICT_SLOTS  = 4096;
   localparam int                   SETTLE_CYC  = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   req_word_type         req_word = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_word_type         rsp_word;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [CFG_W-1:0]     csr_wdata = '0;

   lzw_variable_width_encoder DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Encoder image: dictionary, stream state and registers
   logic [19:0]  dict_keys [DICT_SLOTS];
   int unsigned  next_code, cur_prefix, code_width, bit_buf, bit_fill;
   bit           prefix_valid, header_sent;
   int unsigned  start_bits_reg, max_bits_reg;

   rsp_word_type expected_bytes[$];
   logic [7:0]   typed_headers[$];
   int           fail_count, item_count, byte_count, stream_count;
   int           snd_idle, rcv_idle;

   function automatic int unsigned eff_max();
      return (max_bits_reg > 12) ? 12 : max_bits_reg;
   endfunction

   function automatic int unsigned width_mask(int unsigned w);
      return (32'd1 << w) - 1;
   endfunction

   task automatic emit_byte(int unsigned b);
      rsp_word_type r;
      r.packed_byte = b[7:0];
      r.run_last = 1'b0;
      r.stream_done = 1'b0;
      expected_bytes = {expected_bytes, r};
   endtask

   task automatic emit_code(int unsigned code);
      int unsigned acc, total;
      acc = bit_buf | ((code & width_mask(code_width)) << bit_fill);
      total = bit_fill + code_width;
      while (total >= 8) begin
         emit_byte(acc & 8'hFF);
         acc = acc >> 8;
         total -= 8;
      end
      bit_buf = acc & 7'h7F;
      bit_fill = total;
   endtask

   task automatic clear_stream();
      next_code = FIRST_FREE;
      cur_prefix = 0;
      prefix_valid = 1'b0;
      code_width = start_bits_reg;
      bit_buf = 0;
      bit_fill = 0;
      header_sent = 1'b0;
   endtask

   // Work out the bytes that one input word produces
   task automatic predict_word(req_word_type w);
      int          n;
      int unsigned key, k;
      bit          hit;
      n = expected_bytes.size();
      if (!header_sent) begin
         next_code = FIRST_FREE;
         code_width = start_bits_reg;
         emit_byte(eff_max());
         header_sent = 1'b1;
         if (typed_headers.size() > 0) begin
            if (typed_headers[0] != eff_max()) begin
               $error("header: expected %0d actual %0d", typed_headers[0], eff_max());
               fail_count++;
            end
            void'(typed_headers.pop_front());
         end
      end
      if (!prefix_valid) begin
         cur_prefix = 32'(w.data_byte);
         prefix_valid = 1'b1;
      end else begin
         key = (cur_prefix << 8) | 32'(w.data_byte);
         hit = 1'b0;
         for (k = FIRST_FREE; k < next_code && k < DICT_SLOTS && !hit; k++)
            if (dict_keys[k] == key[19:0]) begin
               hit = 1'b1;
               cur_prefix = k;
            end
         if (!hit) begin
            emit_code(cur_prefix);
            if (next_code > width_mask(code_width)) code_width++;
            if (code_width > eff_max()) begin
               code_width = start_bits_reg;
               next_code = FIRST_FREE;
            end else if (next_code < DICT_SLOTS) begin
               dict_keys[next_code] = key[19:0];
               next_code++;
            end
            cur_prefix = 32'(w.data_byte);
         end
      end
      if (w.end_of_input) begin
         emit_code(cur_prefix);
         if (bit_fill > 0) emit_byte(bit_buf);
         if (expected_bytes.size() > n) expected_bytes[$].stream_done = 1'b1;
         clear_stream();
      end
      if (expected_bytes.size() > n) expected_bytes[$].run_last = 1'b1;
   endtask

   // Check popped words, then advance the image on accepted input and writes
   always @(posedge clock) begin
      if (reset) begin
         start_bits_reg = 32'(START_BITS_RST);
         max_bits_reg = 32'(MAX_BITS_RST);
         clear_stream();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected word %h", rsp_word);
               fail_count++;
            end else begin
               if (rsp_word.packed_byte != expected_bytes[0].packed_byte) begin
                  $error("packed_byte: expected %h actual %h",
                         expected_bytes[0].packed_byte, rsp_word.packed_byte);
                  fail_count++;
               end
               if (rsp_word.run_last != expected_bytes[0].run_last) begin
                  $error("run_last: expected %b actual %b",
                         expected_bytes[0].run_last, rsp_word.run_last);
                  fail_count++;
               end
               if (rsp_word.stream_done != expected_bytes[0].stream_done) begin
                  $error("stream_done: expected %b actual %b",
                         expected_bytes[0].stream_done, rsp_word.stream_done);
                  fail_count++;
               end
               void'(expected_bytes.pop_front());
               byte_count++;
            end
         end
         if (csr_we) begin
            case (csr_idx)
               CSR_START_BITS: start_bits_reg = 32'(csr_wdata);
               CSR_MAX_BITS:   max_bits_reg = 32'(csr_wdata);
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predict_word(req_word);
            item_count++;
            if (req_word.end_of_input) stream_count++;
         end
      end
   end

   // Receiver: stall at the phase's rate
   always @(negedge clock)
      rsp_pop = ($urandom_range(99) >= rcv_idle);

   // Present one word and hold it until it is taken
   task automatic send_word(logic [7:0] b, logic eoi);
      while ($urandom_range(99) < snd_idle) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push = 1'b1;
      req_word.data_byte = b;
      req_word.end_of_input = eoi;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Hold off until every expected word has come, then let the block settle
   task automatic drain();
      req_push = 1'b0;
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      csr_we = 1'b1;
      csr_idx = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random streams: small alphabets for dictionary hits, full range for misses
   task automatic run_streams(int count, bit one_stream);
      int          len, i;
      bit          narrow;
      logic [7:0]  base, b;
      while (count > 0) begin
         len = one_stream ? count :
               ($urandom_range(9) < 7 ? $urandom_range(2, 30) : $urandom_range(1, 3));
         if (len > count) len = count;
         narrow = one_stream ? 1'b0 : 1'($urandom_range(1));
         base = 8'($urandom_range(255));
         for (i = 0; i < len; i++) begin
            b = narrow ? 8'(base + $urandom_range(3)) : 8'($urandom_range(255));
            send_word(b, i == len - 1);
         end
         count -= len;
      end
   endtask

   typedef struct {
      logic [7:0] data;
      logic       eoi;
      bit         chk_hdr;
      logic [7:0] hdr;
   } stim_row_type;

   // Directed rows under the reset settings: extremes, repeats, alternation
   stim_row_type directed_rows[] = '{
      '{8'h00, 1'b1, 1'b1, 8'd11}, '{8'hFF, 1'b1, 1'b1, 8'd11},
      '{8'h41, 1'b0, 1'b1, 8'd11}, '{8'h42, 1'b0, 1'b0, 8'd0}, '{8'h41, 1'b0, 1'b0, 8'd0},
      '{8'h42, 1'b0, 1'b0, 8'd0}, '{8'h41, 1'b0, 1'b0, 8'd0}, '{8'h42, 1'b0, 1'b0, 8'd0},
      '{8'h41, 1'b0, 1'b0, 8'd0}, '{8'h41, 1'b0, 1'b0, 8'd0}, '{8'h41, 1'b0, 1'b0, 8'd0},
      '{8'h41, 1'b0, 1'b0, 8'd0}, '{8'h41, 1'b1, 1'b0, 8'd0},
      '{8'hFF, 1'b0, 1'b1, 8'd11}, '{8'h00, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0}, '{8'hFF, 1'b0, 1'b0, 8'd0}, '{8'h00, 1'b0, 1'b0, 8'd0},
      '{8'hAA, 1'b0, 1'b0, 8'd0}, '{8'h55, 1'b1, 1'b0, 8'd0}
   };

   typedef struct {
      int start_val, max_val, mode, items;
      bit one_stream;
   } phase_type;

   // Settings per phase: both ends of the range, start above max, widths below 9
   phase_type phases[] = '{
      '{9, 9, 0, 120, 1'b1}, '{12, 12, 0, 42, 1'b0}, '{9, 12, 0, 42, 1'b0},
      '{12, 9, 1, 42, 1'b0}, '{0, 0, 1, 42, 1'b0}, '{15, 15, 1, 42, 1'b0},
      '{4, 10, 2, 42, 1'b0}, '{10, 11, 2, 42, 1'b0}
   };

   initial begin
      snd_idle = 18;
      rcv_idle = 78;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      foreach (directed_rows[r]) begin
         if (directed_rows[r].chk_hdr)
            typed_headers = {typed_headers, directed_rows[r].hdr};
         send_word(directed_rows[r].data, directed_rows[r].eoi);
      end
      foreach (phases[p]) begin
         drain();
         write_reg(CSR_START_BITS, CFG_W'(phases[p].start_val));
         write_reg(CSR_MAX_BITS, CFG_W'(phases[p].max_val));
         if (p == 2) begin
            write_reg(CSR_SPARE_A, 4'hF);
            write_reg(CSR_SPARE_B, 4'h0);
         end
         snd_idle = (phases[p].mode == 0) ? 18 : (phases[p].mode == 1) ? 78 : 0;
         rcv_idle = (phases[p].mode == 0) ? 78 : (phases[p].mode == 1) ? 18 : 0;
         if (p == 3) begin
            run_streams(20, 1'b0);
            drain();
            run_streams(phases[p].items - 20, 1'b0);
         end else begin
            run_streams(phases[p].items, phases[p].one_stream);
         end
      end
      drain();
      $display("Covered %0d input words in %0d streams over %0d register settings,",
               item_count, stream_count, phases.size() + 1);
      $display("checked %0d compressed bytes.", byte_count);
      if (fail_count == 0 && expected_bytes.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #8ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule
